>>> hw/rtl/dswc_pkg.sv
package dswc_pkg;

  localparam int unsigned MinW = 11;
  localparam logic [MinW-1:0] DAY_MINUTES = 11'd1440;
  localparam logic [6:0] FULL_BRIGHT = 7'd100;

  // floor(sec / 60) equals ((sec >> 2) * MIN_RECIP) >> MIN_SHIFT for every 17-bit sec.
  localparam logic [15:0] MIN_RECIP = 16'd34953;
  localparam int unsigned MIN_SHIFT = 19;

  localparam logic [1:0] CMD_POLL   = 2'd0;
  localparam logic [1:0] CMD_NUDGE  = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  localparam logic [2:0] WHY_OFF     = 3'd0;
  localparam logic [2:0] WHY_WAITING = 3'd1;
  localparam logic [2:0] WHY_AWAKE   = 3'd2;
  localparam logic [2:0] WHY_WOKEN   = 3'd3;
  localparam logic [2:0] WHY_ASLEEP  = 3'd4;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_START  = 3'd1;
  localparam logic [2:0] REG_STOP   = 3'd2;
  localparam logic [2:0] REG_DIM    = 3'd3;
  localparam logic [2:0] REG_HOLD   = 3'd4;

  function automatic logic in_window(input logic [MinW-1:0] m,
                                     input logic [MinW-1:0] s,
                                     input logic [MinW-1:0] e);
    logic res;
    if (s == e) begin
      res = 1'b0;
    end else if (s < e) begin
      res = (m >= s) && (m < e);
    end else begin
      res = (m >= s) || (m < e);
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/display_sleep_window_control_top.sv
// Display sleep window control.
// Input channel (in_valid/in_stall): one command per transfer (poll, nudge,
// cancel) with the millisecond timestamp and the local second of day.
// Result channel (out_valid/out_stall): one result per input transfer, in
// order: the sleep decision, its reason, panel brightness and power, render
// skip and the minutes to the next window boundary.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 enable,
// 1 window start, 2 window stop, 3 dim level, 4 hold time); write it only
// while no item is in flight.
// On the way from input transfer to result valid, the first register
// holds the item with its minute of day (one 15x16 reciprocal multiply),
// the second holds the result computed from the wake-hold deadline. One
// item per cycle is sustained while out_stall is low; the deadline register
// is updated as each item enters the result register, so the next item
// sees it. A stalled receiver holds the result; one more item may be
// taken into the first register, after which in_stall follows out_stall.
// Reset clears both valid flags and the deadline and loads the register
// defaults (disabled, window 1320 to 420, dim 0, hold 60000 ms).
module display_sleep_window_control_top
  import dswc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic        in_time_known,
  input  logic [16:0] in_second_of_day,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_asleep,
  output logic [2:0]  out_reason,
  output logic [6:0]  out_brightness,
  output logic        out_power_on,
  output logic        out_skip_render,
  output logic        out_change_known,
  output logic [10:0] out_minutes_to_change,
  output logic        out_change_to_sleep
);

  // Configuration registers.
  logic            enable_r;
  logic [MinW-1:0] start_r;
  logic [MinW-1:0] stop_r;
  logic [6:0]      dim_r;
  logic [31:0]     hold_ms_r;
  logic [31:0]     deadline_r, deadline_nxt;

  // Input stage.
  logic            s1_valid_r;
  logic [1:0]      s1_cmd_r;
  logic            s1_known_r;
  logic [MinW-1:0] s1_minute_r;
  logic [31:0]     s1_now_r;
  logic [31:0]     s1_nudge_r;

  logic            out_valid_r;
  logic            advance;
  logic            in_fire;
  logic            s1_fire;

  assign advance  = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // Minute of day from the second of day. Dropping the two low bits first
  // leaves a division by 15, which a 16-bit reciprocal covers exactly.
  logic [14:0]     sec_q;
  logic [30:0]     sec_prod;
  logic [11:0]     min_raw;
  logic [MinW-1:0] min_wrap;
  logic [31:0]     nudge_sum;

  always_comb begin
    sec_q    = in_second_of_day[16:2];
    sec_prod = 31'(sec_q) * 31'(MIN_RECIP);
    min_raw  = sec_prod[MIN_SHIFT+11:MIN_SHIFT];
    if (min_raw >= 12'(DAY_MINUTES)) begin
      min_wrap = MinW'(min_raw - 12'(DAY_MINUTES));
    end else begin
      min_wrap = min_raw[MinW-1:0];
    end
    nudge_sum = in_now_ms + hold_ms_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r    <= in_command;
      s1_known_r  <= in_time_known;
      s1_minute_r <= min_wrap;
      s1_now_r    <= in_now_ms;
      s1_nudge_r  <= nudge_sum;
    end
  end

  // Decision for the item in the input stage.
  logic [31:0]     dl_cmd;
  logic [31:0]     dl_diff;
  logic            pending;
  logic            inside_c;
  logic [2:0]      why_c;
  logic            asleep_c;
  logic            ck_c;
  logic [MinW-1:0] target_c;
  logic [MinW-1:0] mins_c;
  logic            to_sleep_c;

  always_comb begin
    unique case (s1_cmd_r)
      CMD_NUDGE: begin
        if (hold_ms_r != 32'd0) begin
          dl_cmd = (s1_nudge_r == 32'd0) ? 32'd1 : s1_nudge_r;
        end else begin
          dl_cmd = deadline_r;
        end
      end
      CMD_CANCEL: dl_cmd = 32'd0;
      default:    dl_cmd = deadline_r;
    endcase
    dl_diff  = s1_now_r - dl_cmd;
    pending  = (dl_cmd != 32'd0) && dl_diff[31];
    inside_c = in_window(s1_minute_r, start_r, stop_r);

    priority if (!enable_r) begin
      why_c = WHY_OFF;
    end else if (!s1_known_r) begin
      why_c = WHY_WAITING;
    end else if (!inside_c) begin
      why_c = WHY_AWAKE;
    end else if (pending) begin
      why_c = WHY_WOKEN;
    end else begin
      why_c = WHY_ASLEEP;
    end
    asleep_c = (why_c == WHY_ASLEEP);

    ck_c     = enable_r && (start_r != stop_r) && s1_known_r;
    target_c = inside_c ? stop_r : start_r;
    if (!ck_c) begin
      mins_c     = '0;
      to_sleep_c = 1'b0;
    end else begin
      if (target_c >= s1_minute_r) begin
        mins_c = target_c - s1_minute_r;
      end else begin
        mins_c = target_c + DAY_MINUTES - s1_minute_r;
      end
      to_sleep_c = !inside_c;
    end

    if (s1_cmd_r == CMD_POLL && asleep_c) begin
      deadline_nxt = 32'd0;
    end else begin
      deadline_nxt = dl_cmd;
    end
  end

  // Configuration writes and the deadline; a disable write clears the hold.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      start_r    <= 11'd1320;
      stop_r     <= 11'd420;
      dim_r      <= 7'd0;
      hold_ms_r  <= 32'd60000;
      deadline_r <= 32'd0;
    end else begin
      if (s1_fire) begin
        deadline_r <= deadline_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLE: begin
            enable_r <= cfg_data[0];
            if (!cfg_data[0]) begin
              deadline_r <= 32'd0;
            end
          end
          REG_START: begin
            if (cfg_data[MinW-1:0] < DAY_MINUTES) begin
              start_r <= cfg_data[MinW-1:0];
            end
          end
          REG_STOP: begin
            if (cfg_data[MinW-1:0] < DAY_MINUTES) begin
              stop_r <= cfg_data[MinW-1:0];
            end
          end
          REG_DIM:  dim_r <= (cfg_data[6:0] > FULL_BRIGHT) ? FULL_BRIGHT : cfg_data[6:0];
          REG_HOLD: hold_ms_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (advance) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_asleep            <= asleep_c;
      out_reason            <= why_c;
      out_brightness        <= (asleep_c && dim_r != 7'd0) ? dim_r : FULL_BRIGHT;
      out_power_on          <= !asleep_c || (dim_r != 7'd0);
      out_skip_render       <= asleep_c && (dim_r == 7'd0);
      out_change_known      <= ck_c;
      out_minutes_to_change <= mins_c;
      out_change_to_sleep   <= to_sleep_c;
    end
  end

  a_poll_asleep_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_cmd_r == CMD_POLL && asleep_c |=> deadline_r == 32'd0)
    else $error("asleep poll left a wake hold pending");

  a_disable_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == REG_ENABLE && !cfg_data[0] |=> deadline_r == 32'd0)
    else $error("disable write left a wake hold pending");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room in the pipeline");

  a_panel_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_power_on == !out_skip_render) &&
                    (out_asleep == (out_reason == WHY_ASLEEP)))
    else $error("panel settings disagree with the decision");

  a_unknown_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_change_known |-> out_minutes_to_change == '0 && !out_change_to_sleep)
    else $error("boundary reported while change is unknown");

endmodule
